>>> design/mpd_pkg.sv
// Package for the media packet deframer: sizes, codes and the types that
// pass between the controller and the datapath. Depends on nothing.
`default_nettype none

package mpd_pkg;

    // Depth of the stored codec config and the widths that follow from it.
    localparam int CONFIG_DEPTH = 64;
    localparam int ADDR_W       = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1;
    localparam int CLEN_W       = $clog2(CONFIG_DEPTH + 1);

    // Last byte position of each header section, and the header split.
    localparam logic [3:0] CODEC_LAST_POS = 4'd3;
    localparam logic [3:0] SIZE_LAST_POS  = 4'd7;
    localparam logic [3:0] HDR_SPLIT_POS  = 4'd8;
    localparam logic [3:0] HDR_LAST_POS   = 4'd11;

    // Codec words as they appear in the stream.
    localparam logic [31:0] WORD_DISABLED = 32'h0000_0000;
    localparam logic [31:0] WORD_DEV_ERR  = 32'h0000_0001;
    localparam logic [31:0] WORD_H264     = 32'h6832_3634;
    localparam logic [31:0] WORD_H265     = 32'h6832_3635;
    localparam logic [31:0] WORD_AV1      = 32'h0061_7631;
    localparam logic [31:0] WORD_OPUS     = 32'h6f70_7573;
    localparam logic [31:0] WORD_AAC      = 32'h0061_6163;
    localparam logic [31:0] WORD_RAW      = 32'h0072_6177;

    // Codec codes reported on the output.
    localparam logic [2:0] CODEC_H264 = 3'd0;
    localparam logic [2:0] CODEC_H265 = 3'd1;
    localparam logic [2:0] CODEC_AV1  = 3'd2;
    localparam logic [2:0] CODEC_OPUS = 3'd3;
    localparam logic [2:0] CODEC_AAC  = 3'd4;
    localparam logic [2:0] CODEC_RAW  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_INFO   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_ENDED  = 2'd2;

    // End-of-stream status codes.
    localparam logic [1:0] STAT_DISABLED    = 2'd0;
    localparam logic [1:0] STAT_DEV_ERR     = 2'd1;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;
    localparam logic [1:0] STAT_CFG_LARGE   = 2'd3;

    // Controller phases.
    typedef enum logic [2:0] {
        PH_CODEC,
        PH_SIZE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_REPLAY,
        PH_ENDED
    } mpd_phase_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CODEC_SHIFT,
        OP_CODEC_DONE,
        OP_SIZE_SHIFT,
        OP_SIZE_DONE,
        OP_HDR_SHIFT,
        OP_HDR_DONE,
        OP_PAY_BYTE,
        OP_REPLAY_BYTE
    } mpd_op_t;

    // Which result row the output register loads.
    typedef enum logic [1:0] {
        ROW_STATUS,
        ROW_INFO,
        ROW_PAYLOAD,
        ROW_REPLAY
    } mpd_row_t;

    // Class of a completed codec word.
    typedef enum logic [2:0] {
        WC_DISABLED,
        WC_DEV_ERR,
        WC_AUDIO,
        WC_VIDEO,
        WC_UNKNOWN
    } mpd_word_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        mpd_op_t    op;
        logic       emit;
        mpd_row_t   row;
        logic [1:0] status;
    } mpd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] byte_pos;
        mpd_word_t  word_class;
        logic       size_zero;
        logic       hdr_cfg;
        logic       video;
        logic       config_held;
        logic       oversize;
        logic       last_byte;
        logic       replay_last;
    } mpd_stat_t;

endpackage : mpd_pkg

`default_nettype wire

>>> design/mpd_ctrl.sv
// Controller of the media packet deframer: phase state machine, input and
// output handshakes. Depends on mpd_pkg.
`default_nettype none

module mpd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire mpd_pkg::mpd_stat_t stat,
    output mpd_pkg::mpd_cmd_t      cmd
);
    import mpd_pkg::*;

    mpd_phase_t phase_reg;
    mpd_phase_t phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       take;

    // The output register may load when it is empty or drained this cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = slot_free && (phase_reg != PH_REPLAY);
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_CODEC:
            begin
                if (take && stat.byte_pos == CODEC_LAST_POS)
                begin
                    case (stat.word_class)
                        WC_AUDIO: phase_next = PH_HEADER;
                        WC_VIDEO: phase_next = PH_SIZE;
                        default:  phase_next = PH_ENDED;
                    endcase
                end
            end
            PH_SIZE:
            begin
                if (take && stat.byte_pos == SIZE_LAST_POS)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (take && stat.byte_pos == HDR_LAST_POS && !stat.size_zero)
                begin
                    if (stat.video && stat.hdr_cfg)
                    begin
                        phase_next = stat.oversize ? PH_ENDED : PH_PAYLOAD;
                    end
                    else if (stat.video && stat.config_held)
                    begin
                        phase_next = PH_REPLAY;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (take && stat.last_byte)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_REPLAY:
            begin
                if (slot_free && stat.replay_last)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
                phase_next = PH_ENDED;
            end
        endcase
    end

    // Datapath commands and result emission.
    always_comb
    begin
        cmd.op     = OP_IDLE;
        cmd.emit   = 1'b0;
        cmd.row    = ROW_STATUS;
        cmd.status = STAT_DISABLED;
        case (phase_reg)
            PH_CODEC:
            begin
                if (take)
                begin
                    if (stat.byte_pos == CODEC_LAST_POS)
                    begin
                        cmd.op   = OP_CODEC_DONE;
                        cmd.emit = (stat.word_class != WC_VIDEO);
                        case (stat.word_class)
                            WC_AUDIO:    cmd.row = ROW_INFO;
                            WC_DISABLED: cmd.status = STAT_DISABLED;
                            WC_DEV_ERR:  cmd.status = STAT_DEV_ERR;
                            default:     cmd.status = STAT_UNSUPPORTED;
                        endcase
                    end
                    else
                    begin
                        cmd.op = OP_CODEC_SHIFT;
                    end
                end
            end
            PH_SIZE:
            begin
                if (take)
                begin
                    if (stat.byte_pos == SIZE_LAST_POS)
                    begin
                        cmd.op   = OP_SIZE_DONE;
                        cmd.emit = 1'b1;
                        cmd.row  = ROW_INFO;
                    end
                    else
                    begin
                        cmd.op = OP_SIZE_SHIFT;
                    end
                end
            end
            PH_HEADER:
            begin
                if (take)
                begin
                    if (stat.byte_pos == HDR_LAST_POS)
                    begin
                        cmd.op     = OP_HDR_DONE;
                        cmd.emit   = !stat.size_zero && stat.video && stat.hdr_cfg
                                     && stat.oversize;
                        cmd.status = STAT_CFG_LARGE;
                    end
                    else
                    begin
                        cmd.op = OP_HDR_SHIFT;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (take)
                begin
                    cmd.op   = OP_PAY_BYTE;
                    cmd.emit = 1'b1;
                    cmd.row  = ROW_PAYLOAD;
                end
            end
            PH_REPLAY:
            begin
                if (slot_free)
                begin
                    cmd.op   = OP_REPLAY_BYTE;
                    cmd.emit = 1'b1;
                    cmd.row  = ROW_REPLAY;
                end
            end
            default:
            begin
                cmd.op = OP_IDLE;
            end
        endcase
    end

    // Output valid follows loads and drains.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CODEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : mpd_ctrl

`default_nettype wire

>>> design/mpd_dp.sv
// Datapath of the media packet deframer: header shift registers, counters,
// config store and the output register. Depends on mpd_pkg.
`default_nettype none

module mpd_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        in_byte,
    input  wire mpd_pkg::mpd_cmd_t cmd,
    output mpd_pkg::mpd_stat_t     stat,
    output logic [1:0]             kind,
    output logic [2:0]             codec,
    output logic [31:0]            frame_width,
    output logic [31:0]            frame_height,
    output logic [1:0]             status,
    output logic [7:0]             data_byte,
    output logic [61:0]            timestamp,
    output logic                   timestamp_valid,
    output logic                   key_frame,
    output logic [32:0]            packet_length,
    output logic                   last_of_packet
);
    import mpd_pkg::*;

    // Control state.
    logic [3:0]        byte_pos_reg;
    logic [3:0]        byte_pos_next;
    logic [2:0]        codec_kind_reg;
    logic [2:0]        codec_kind_next;
    logic              video_reg;
    logic              video_next;
    logic              held_reg;
    logic              held_next;
    logic [CLEN_W-1:0] cfg_len_reg;
    logic [CLEN_W-1:0] cfg_len_next;
    logic [CLEN_W-1:0] ridx_reg;
    logic [CLEN_W-1:0] ridx_next;

    // Payload state.
    logic [63:0] hs_reg;
    logic [63:0] hs_next;
    logic [31:0] sh_reg;
    logic [31:0] sh_next;
    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic [32:0] total_reg;
    logic [32:0] total_next;

    // Config store.
    logic [7:0]        mem [CONFIG_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_off;

    // Output register.
    logic [1:0]  kind_reg;
    logic [2:0]  codec_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [1:0]  status_reg;
    logic [7:0]  data_reg;
    logic [61:0] ts_reg;
    logic        tsv_reg;
    logic        key_reg;
    logic [32:0] plen_reg;
    logic        last_reg;

    // Row being built.
    logic [1:0]  row_kind;
    logic [2:0]  row_codec;
    logic [31:0] row_width;
    logic [31:0] row_height;
    logic [1:0]  row_status;
    logic [7:0]  row_data;
    logic [61:0] row_ts;
    logic        row_tsv;
    logic        row_key;
    logic [32:0] row_plen;
    logic        row_last;

    logic [63:0] hs_shift;
    logic [31:0] sh_shift;
    logic [2:0]  word_code;
    mpd_word_t   word_class;
    logic        replay_start;

    assign hs_shift = {hs_reg[55:0], in_byte};
    assign sh_shift = {sh_reg[23:0], in_byte};

    // Classify the completed codec word.
    always_comb
    begin
        word_code  = CODEC_H264;
        word_class = WC_UNKNOWN;
        case (sh_shift)
            WORD_DISABLED: word_class = WC_DISABLED;
            WORD_DEV_ERR:  word_class = WC_DEV_ERR;
            WORD_H264:
            begin
                word_code  = CODEC_H264;
                word_class = WC_VIDEO;
            end
            WORD_H265:
            begin
                word_code  = CODEC_H265;
                word_class = WC_VIDEO;
            end
            WORD_AV1:
            begin
                word_code  = CODEC_AV1;
                word_class = WC_VIDEO;
            end
            WORD_OPUS:
            begin
                word_code  = CODEC_OPUS;
                word_class = WC_AUDIO;
            end
            WORD_AAC:
            begin
                word_code  = CODEC_AAC;
                word_class = WC_AUDIO;
            end
            WORD_RAW:
            begin
                word_code  = CODEC_RAW;
                word_class = WC_AUDIO;
            end
            default:
            begin
                word_class = WC_UNKNOWN;
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        stat.byte_pos    = byte_pos_reg;
        stat.word_class  = word_class;
        stat.size_zero   = (sh_shift == 32'd0);
        stat.hdr_cfg     = hs_reg[63];
        stat.video       = video_reg;
        stat.config_held = held_reg;
        stat.oversize    = (sh_shift > 32'(CONFIG_DEPTH));
        stat.last_byte   = (left_reg <= 32'd1);
        stat.replay_last = ((ridx_reg + 1'b1) == cfg_len_reg);
    end

    // A non-config header with nonzero size in a video stream with held config starts the replay.
    assign replay_start = (cmd.op == OP_HDR_DONE) && (sh_shift != 32'd0) && video_reg
                          && !hs_reg[63] && held_reg;

    // State updates for each operation.
    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        codec_kind_next = codec_kind_reg;
        video_next      = video_reg;
        held_next       = held_reg;
        cfg_len_next    = cfg_len_reg;
        ridx_next       = ridx_reg;
        hs_next         = hs_reg;
        sh_next         = sh_reg;
        left_next       = left_reg;
        total_next      = total_reg;
        case (cmd.op)
            OP_CODEC_SHIFT:
            begin
                sh_next       = sh_shift;
                byte_pos_next = byte_pos_reg + 4'd1;
            end
            OP_CODEC_DONE:
            begin
                byte_pos_next = 4'd0;
                if (word_class == WC_AUDIO || word_class == WC_VIDEO)
                begin
                    sh_next         = 32'd0;
                    codec_kind_next = word_code;
                    video_next      = (word_class == WC_VIDEO);
                end
                else
                begin
                    sh_next = sh_shift;
                end
            end
            OP_SIZE_SHIFT:
            begin
                hs_next       = hs_shift;
                byte_pos_next = byte_pos_reg + 4'd1;
            end
            OP_SIZE_DONE:
            begin
                hs_next       = 64'd0;
                byte_pos_next = 4'd0;
            end
            OP_HDR_SHIFT:
            begin
                if (byte_pos_reg < HDR_SPLIT_POS)
                begin
                    hs_next = hs_shift;
                end
                else
                begin
                    sh_next = sh_shift;
                end
                byte_pos_next = byte_pos_reg + 4'd1;
            end
            OP_HDR_DONE:
            begin
                sh_next       = sh_shift;
                byte_pos_next = 4'd0;
                if (sh_shift != 32'd0)
                begin
                    total_next = {1'b0, sh_shift};
                    left_next  = sh_shift;
                    if (video_reg && hs_reg[63])
                    begin
                        if (sh_shift <= 32'(CONFIG_DEPTH))
                        begin
                            cfg_len_next = sh_shift[CLEN_W-1:0];
                            held_next    = 1'b1;
                        end
                    end
                    else if (replay_start)
                    begin
                        total_next = {1'b0, sh_shift} + 33'(cfg_len_reg);
                        held_next  = 1'b0;
                        ridx_next  = '0;
                    end
                end
            end
            OP_PAY_BYTE:
            begin
                if (left_reg <= 32'd1)
                begin
                    left_next = 32'd0;
                    hs_next   = 64'd0;
                    sh_next   = 32'd0;
                end
                else
                begin
                    left_next = left_reg - 32'd1;
                end
            end
            OP_REPLAY_BYTE:
            begin
                ridx_next = ridx_reg + 1'b1;
            end
            default:
            begin
                byte_pos_next = byte_pos_reg;
            end
        endcase
    end

    // Config store access: write during a video config payload, read ahead
    // during the replay.
    assign wr_off  = sh_reg - left_reg;
    assign wr_addr = wr_off[ADDR_W-1:0];
    assign wr_en   = (cmd.op == OP_PAY_BYTE) && video_reg && hs_reg[63];
    assign rd_en   = replay_start || (cmd.op == OP_REPLAY_BYTE);

    always_comb
    begin
        if (cmd.op == OP_REPLAY_BYTE)
        begin
            rd_addr = ridx_next[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Build the result row.
    always_comb
    begin
        row_kind   = KIND_ENDED;
        row_codec  = codec_kind_reg;
        row_width  = 32'd0;
        row_height = 32'd0;
        row_status = cmd.status;
        row_data   = 8'd0;
        row_ts     = 62'd0;
        row_tsv    = 1'b0;
        row_key    = 1'b0;
        row_plen   = 33'd0;
        row_last   = 1'b0;
        case (cmd.row)
            ROW_STATUS:
            begin
                row_kind = KIND_ENDED;
            end
            ROW_INFO:
            begin
                row_kind   = KIND_INFO;
                row_codec  = codec_kind_next;
                row_status = STAT_DISABLED;
                if (cmd.op == OP_SIZE_DONE)
                begin
                    row_width  = hs_shift[63:32];
                    row_height = hs_shift[31:0];
                end
            end
            default:
            begin
                row_kind   = KIND_PACKET;
                row_status = STAT_DISABLED;
                row_data   = (cmd.row == ROW_REPLAY) ? rd_data_reg : in_byte;
                row_ts     = hs_reg[63] ? 62'd0 : hs_reg[61:0];
                row_tsv    = !hs_reg[63];
                row_key    = hs_reg[62];
                row_plen   = total_reg;
                row_last   = (cmd.row == ROW_PAYLOAD) && (left_reg <= 32'd1);
            end
        endcase
    end

    // Output register, loaded when the controller emits a result.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg   <= row_kind;
            codec_reg  <= row_codec;
            width_reg  <= row_width;
            height_reg <= row_height;
            status_reg <= row_status;
            data_reg   <= row_data;
            ts_reg     <= row_ts;
            tsv_reg    <= row_tsv;
            key_reg    <= row_key;
            plen_reg   <= row_plen;
            last_reg   <= row_last;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= 4'd0;
            codec_kind_reg <= CODEC_H264;
            video_reg      <= 1'b0;
            held_reg       <= 1'b0;
            cfg_len_reg    <= '0;
            ridx_reg       <= '0;
            hs_reg         <= 64'd0;
            sh_reg         <= 32'd0;
            left_reg       <= 32'd0;
            total_reg      <= 33'd0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            codec_kind_reg <= codec_kind_next;
            video_reg      <= video_next;
            held_reg       <= held_next;
            cfg_len_reg    <= cfg_len_next;
            ridx_reg       <= ridx_next;
            hs_reg         <= hs_next;
            sh_reg         <= sh_next;
            left_reg       <= left_next;
            total_reg      <= total_next;
        end
    end

    assign kind            = kind_reg;
    assign codec           = codec_reg;
    assign frame_width     = width_reg;
    assign frame_height    = height_reg;
    assign status          = status_reg;
    assign data_byte       = data_reg;
    assign timestamp       = ts_reg;
    assign timestamp_valid = tsv_reg;
    assign key_frame       = key_reg;
    assign packet_length   = plen_reg;
    assign last_of_packet  = last_reg;

endmodule : mpd_dp

`default_nettype wire

>>> design/media_packet_deframer.sv
// Media packet deframer: one stream byte per transfer in, one result per
// transfer out. Each result is registered and appears in the cycle after its
// input transfer. Throughput is one byte per cycle while the output is not
// stalled; a media header that follows a stored video config holds the input
// while the config store's single read port replays it (up to 64 bytes).
// Reset is asynchronous and active low; it returns the block to reading the codec word.
`default_nettype none

module media_packet_deframer (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // stream_byte[7:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // codec[2:0], frame_width[34:3], frame_height[66:35], status[68:67],
    // data_byte[76:69], timestamp[138:77], timestamp_valid[139],
    // key_frame[140], packet_length[173:141], zero fill[175:174]
    output logic [175:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // kind[1:0]
    output logic              m_axis_tlast    // last_of_packet
);
    import mpd_pkg::*;

    mpd_cmd_t    cmd;
    mpd_stat_t   stat;
    logic [1:0]  kind;
    logic [2:0]  codec;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [61:0] timestamp;
    logic        timestamp_valid;
    logic        key_frame;
    logic [32:0] packet_length;
    logic        last_of_packet;

    // Phase control and handshakes.
    mpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Header parsing, config store and output register.
    mpd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_byte         (s_axis_tdata),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .codec           (codec),
        .frame_width     (frame_width),
        .frame_height    (frame_height),
        .status          (status),
        .data_byte       (data_byte),
        .timestamp       (timestamp),
        .timestamp_valid (timestamp_valid),
        .key_frame       (key_frame),
        .packet_length   (packet_length),
        .last_of_packet  (last_of_packet)
    );

    // Pack the result fields onto the stream.
    assign m_axis_tdata = {2'b00, packet_length, key_frame, timestamp_valid, timestamp,
                           data_byte, status, frame_height, frame_width, codec};
    assign m_axis_tuser = kind;
    assign m_axis_tlast = last_of_packet;

endmodule : media_packet_deframer

`default_nettype wire
